// ===== rtl/sid_pkg.sv =====
// shared types and constants for the descending sorted insertion store
package sid_pkg;

	localparam int unsigned VAL_W = 32;
	localparam int unsigned IDX_W = 6;
	localparam int unsigned CNT_W = 7;
	localparam int unsigned OUT_DATA_W = 40;

	typedef struct packed {
		logic             start;
		logic             rd_en;
		logic [IDX_W-1:0] rd_idx;
		logic             load;
		logic [IDX_W-1:0] s1_idx;
	} sid_cmd_t;

	typedef struct packed {
		logic [CNT_W-1:0] total;
	} sid_status_t;

endpackage

// ===== rtl/sid_datapath.sv =====
// store memory, count, insertion and shift logic, output payload registers
module sid_datapath #(
	parameter int unsigned CAPACITY = 64
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  sid_pkg::sid_cmd_t           cmd,
	input  logic [sid_pkg::VAL_W-1:0]   new_value,
	output sid_pkg::sid_status_t        status,
	output logic [sid_pkg::VAL_W-1:0]   entry_value,
	output logic [sid_pkg::IDX_W-1:0]   entry_index,
	output logic                        dropped
);
	import sid_pkg::*;

	localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

	logic [VAL_W-1:0] mem_q [CAPACITY];
	logic [VAL_W-1:0] rd_data_q;
	logic [VAL_W-1:0] new_q;
	logic [VAL_W-1:0] carry_q;
	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] old_count_q;
	logic             drop_q;
	logic             ins_q;

	logic [VAL_W-1:0] wr_val;
	logic             take_new;
	logic             at_end;

	assign at_end   = (CNT_W'(cmd.s1_idx) == old_count_q);
	assign take_new = !drop_q && !ins_q &&
		(at_end || ($signed(rd_data_q) < $signed(new_q)));

	always_comb begin
		if (drop_q) begin
			wr_val = rd_data_q;
		end else if (take_new) begin
			wr_val = new_q;
		end else if (ins_q) begin
			wr_val = carry_q;
		end else begin
			wr_val = rd_data_q;
		end
	end

	// entry count and per-item control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			old_count_q <= '0;
			drop_q      <= 1'b0;
			ins_q       <= 1'b0;
		end else if (cmd.start) begin
			old_count_q <= count_q;
			drop_q      <= (count_q == CAP_CNT);
			ins_q       <= 1'b0;
			if (count_q != CAP_CNT) begin
				count_q <= count_q + CNT_W'(1);
			end
		end else if (cmd.load && take_new) begin
			ins_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			new_q <= new_value;
		end
		if (cmd.load) begin
			carry_q     <= rd_data_q;
			entry_value <= wr_val;
			entry_index <= cmd.s1_idx;
			dropped     <= drop_q;
		end
	end

	// store memory: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (cmd.load && !drop_q) begin
			mem_q[cmd.s1_idx[AW-1:0]] <= wr_val;
		end
		if (cmd.rd_en) begin
			rd_data_q <= mem_q[cmd.rd_idx[AW-1:0]];
		end
	end

	assign status.total = count_q;

endmodule

// ===== rtl/sid_ctrl.sv =====
// controller: item handshake, read sequencing and output handshake
module sid_ctrl (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic                   out_last,
	output sid_pkg::sid_cmd_t      cmd,
	input  sid_pkg::sid_status_t   status
);
	import sid_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_RUN  = 2'b10
	} state_t;

	state_t           state_q;
	logic [CNT_W-1:0] rd_k_q;
	logic [IDX_W-1:0] s1_idx_q;
	logic             s1_valid_q;
	logic             out_valid_q;
	logic             out_last_q;

	logic adv;
	logic load;
	logic issue;
	logic s1_last;

	assign adv     = !out_valid_q || out_ready;
	assign load    = s1_valid_q && adv;
	assign issue   = (state_q == ST_RUN) && (rd_k_q < status.total) && (!s1_valid_q || adv);
	assign s1_last = (CNT_W'(s1_idx_q) == (status.total - CNT_W'(1)));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			rd_k_q      <= '0;
			s1_idx_q    <= '0;
			s1_valid_q  <= 1'b0;
			out_valid_q <= 1'b0;
			out_last_q  <= 1'b0;
		end else begin
			s1_valid_q  <= issue || (s1_valid_q && !adv);
			out_valid_q <= load || (out_valid_q && !out_ready);
			if (issue) begin
				s1_idx_q <= rd_k_q[IDX_W-1:0];
				rd_k_q   <= rd_k_q + CNT_W'(1);
			end
			if (load) begin
				out_last_q <= s1_last;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						state_q <= ST_RUN;
						rd_k_q  <= '0;
					end
				end
				ST_RUN: begin
					if (out_valid_q && out_ready && out_last_q) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign in_ready   = (state_q == ST_IDLE);
	assign out_valid  = out_valid_q;
	assign out_last   = out_last_q;

	assign cmd.start  = (state_q == ST_IDLE) && in_valid;
	assign cmd.rd_en  = issue;
	assign cmd.rd_idx = rd_k_q[IDX_W-1:0];
	assign cmd.load   = load;
	assign cmd.s1_idx = s1_idx_q;

endmodule

// ===== rtl/sorted_insert_descending.sv =====
// top level of the descending sorted insertion store
//
// channel   dir  handshake                 payload
// s_*       in   s_tvalid / s_tready       s_tdata = new_value
// m_*       out  m_tvalid / m_tready       m_tdata = entry_value, entry_index; tlast; tuser
//
// each item has a start step, then one entry per cycle while m_tready does not stall,
// through the store memory's single read port and the output register
// reset clears the entry count; store contents are only read below the count
// s_tready stays low until the last entry of the current dump is taken
// a stall on m_tready holds the output register and pauses the memory reads
module sorted_insert_descending #(
	parameter int unsigned CAPACITY = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // [31:0] new_value
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,   // [31:0] entry_value, [37:32] entry_index, [39:38] zero
	output logic        m_tlast,   // last_entry
	output logic        m_tuser    // [0] dropped
);
	import sid_pkg::*;

	sid_cmd_t         cmd;
	sid_status_t      status;
	logic [VAL_W-1:0] entry_value;
	logic [IDX_W-1:0] entry_index;
	logic             dropped;

	sid_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_last  (m_tlast),
		.cmd       (cmd),
		.status    (status)
	);

	sid_datapath #(
		.CAPACITY (CAPACITY)
	) u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.new_value   (s_tdata),
		.status      (status),
		.entry_value (entry_value),
		.entry_index (entry_index),
		.dropped     (dropped)
	);

	assign m_tdata = {2'b00, entry_index, entry_value};
	assign m_tuser = dropped;

	// no new item while a dump is still on the output
	a_idle_no_out: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready |-> !m_tvalid)
		else $error("item accepted while output pending");

	// drop flag is constant within one dump
	a_drop_steady: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tready && !m_tlast) |=> (!m_tvalid || m_tuser == $past(m_tuser)))
		else $error("drop flag changed inside a dump");

	// entries come out in index order
	a_index_step: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tready && !m_tlast) |=>
		(!m_tvalid || m_tdata[37:32] == 6'($past(m_tdata[37:32]) + 6'd1)))
		else $error("entry index out of sequence");

	// every dump starts at index zero
	a_index_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tready && m_tlast) |=> (!m_tvalid || m_tdata[37:32] == 6'd0))
		else $error("dump does not start at index zero");

endmodule

// ===== tb/tb_sorted_insert_descending.sv =====
// self-checking testbench for the descending sorted insertion store
module tb_sorted_insert_descending;
	timeunit 1ns;
	timeprecision 1ps;

	import sid_pkg::*;

	localparam int unsigned DEPTH = 64;
	localparam int unsigned RANDOM_ITEMS = 200;
	localparam int unsigned IDLE_LIMIT = 2000;
	localparam int unsigned PRINT_LIMIT = 40;

	localparam logic [VAL_W-1:0] DIRECTED [16] = '{
		32'h0000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF,
		32'h0001_0000, 32'h0000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
		32'h0000_0001, 32'hFFFF_0000, 32'h8000_0001, 32'h7FFF_FFFE,
		32'h5555_5555, 32'hAAAA_AAAA, 32'h0000_8000, 32'h0000_8000
	};

	typedef struct packed {
		logic [VAL_W-1:0] value;
		logic [IDX_W-1:0] idx;
		logic             last;
		logic             drop;
	} entry_t;

	class store_tracker;
		logic [VAL_W-1:0] held [DEPTH];
		int unsigned      held_count;
		entry_t           expected_entries [$];
		int unsigned      errors;
		int unsigned      placed;
		int unsigned      discarded;
		int unsigned      entries_seen;

		function new();
			held_count = 0;
			errors = 0;
			placed = 0;
			discarded = 0;
			entries_seen = 0;
		endfunction

		// an accepted item: update the store and queue the dump it causes
		function void note_insert(logic [VAL_W-1:0] v);
			int unsigned pos;
			logic        drop;
			drop = (held_count == DEPTH);
			if (!drop) begin
				pos = 0;
				while (pos < held_count && $signed(held[pos]) >= $signed(v))
					pos++;
				for (int unsigned k = held_count; k > pos; k--)
					held[k] = held[k-1];
				held[pos] = v;
				held_count++;
				placed++;
			end else begin
				discarded++;
			end
			for (int unsigned k = 0; k < held_count; k++)
				expected_entries.push_back(entry_t'{value: held[k], idx: IDX_W'(k),
					last: (k + 1 == held_count), drop: drop});
		endfunction

		function logic [VAL_W-1:0] pick_held();
			if (held_count == 0)
				return '0;
			return held[$urandom_range(0, held_count - 1)];
		endfunction

		function int unsigned pending();
			return expected_entries.size();
		endfunction

		task report(string msg);
			if (errors < PRINT_LIMIT)
				$display("mismatch at %0t: %s", $realtime, msg);
			errors++;
		endtask

		task check_entry(logic [OUT_DATA_W-1:0] data, logic last, logic user);
			entry_t want;
			entries_seen++;
			if (expected_entries.size() == 0) begin
				report($sformatf("unexpected entry data=%h last=%b dropped=%b",
					data, last, user));
				return;
			end
			want = expected_entries.pop_front();
			if (data[31:0] !== want.value)
				report($sformatf("entry %0d value %h, want %h", want.idx, data[31:0],
					want.value));
			if (data[37:32] !== want.idx)
				report($sformatf("entry index %0d, want %0d", data[37:32], want.idx));
			if (data[39:38] !== 2'b00)
				report($sformatf("entry %0d pad bits %b", want.idx, data[39:38]));
			if (last !== want.last)
				report($sformatf("entry %0d last %b, want %b", want.idx, last, want.last));
			if (user !== want.drop)
				report($sformatf("entry %0d dropped %b, want %b", want.idx, user, want.drop));
		endtask
	endclass

	logic                  clk;
	logic                  arst_n;
	logic                  s_tvalid;
	logic                  s_tready;
	logic [31:0]           s_tdata;
	logic                  m_tvalid;
	logic                  m_tready;
	logic [OUT_DATA_W-1:0] m_tdata;
	logic                  m_tlast;
	logic                  m_tuser;

	store_tracker tracker;
	int unsigned  burst_left;
	int unsigned  idle_cycles = 0;

	sorted_insert_descending #(
		.CAPACITY(DEPTH)
	) dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tlast (m_tlast),
		.m_tuser (m_tuser)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	function automatic logic [VAL_W-1:0] pick_value();
		int               n;
		logic [VAL_W-1:0] v;
		case ($urandom_range(0, 5))
			0, 5: v = $urandom();
			1: begin
				n = int'($urandom_range(0, 16)) - 8;
				v = 32'(n) << 16;
			end
			2: begin
				n = int'($urandom_range(0, 131071)) - 65536;
				v = 32'(n);
			end
			3: begin
				case ($urandom_range(0, 3))
					0: v = 32'h7FFF_FFFF;
					1: v = 32'h8000_0000;
					2: v = 32'h0000_0000;
					default: v = 32'hFFFF_FFFF;
				endcase
			end
			default: v = tracker.pick_held();
		endcase
		return v;
	endfunction

	// sender works in bursts, usually with an idle gap between them
	task automatic send_value(input logic [VAL_W-1:0] v);
		int unsigned gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 8);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
			if (gap > 0) begin
				@(negedge clk);
				s_tvalid = 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
		end
		burst_left--;
		@(negedge clk);
		s_tvalid = 1'b1;
		s_tdata = v;
		do
			@(posedge clk);
		while (s_tready !== 1'b1);
		tracker.note_insert(v);
	endtask

	// receiver stall pattern
	initial begin
		int unsigned mode;
		int unsigned span;
		int unsigned phase;
		m_tready = 1'b0;
		phase = 0;
		forever begin
			mode = $urandom_range(0, 3);
			span = $urandom_range(8, 80);
			repeat (span) begin
				@(negedge clk);
				phase++;
				case (mode)
					0: m_tready = 1'b1;
					1: m_tready = 1'($urandom_range(0, 1));
					2: m_tready = ($urandom_range(0, 7) == 0);
					default: m_tready = (phase % 16) >= 12;
				endcase
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid === 1'b1 && m_tready === 1'b1)
			tracker.check_entry(m_tdata, m_tlast, m_tuser);
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("timeout after %0d cycles without an item", idle_cycles);
				$display("FAIL sorted_insert_descending");
				$finish;
			end
		end
	end

	initial begin
		tracker = new();
		burst_left = 0;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		repeat (5) @(negedge clk);
		arst_n = 1'b1;

		// extremes, equal values at front, middle and back
		foreach (DIRECTED[i])
			send_value(DIRECTED[i]);
		// fills the store, then runs on with the store full
		repeat (RANDOM_ITEMS)
			send_value(pick_value());
		@(negedge clk);
		s_tvalid = 1'b0;

		while (tracker.pending() != 0)
			@(posedge clk);
		repeat (3 * DEPTH) @(posedge clk);

		$display("%0d items sent: %0d placed in order, %0d discarded with the store full",
			tracker.placed + tracker.discarded, tracker.placed, tracker.discarded);
		$display("%0d output entries checked, %0d mismatches", tracker.entries_seen,
			tracker.errors);
		if (tracker.errors == 0)
			$display("PASS sorted_insert_descending");
		else
			$display("FAIL sorted_insert_descending");
		$finish;
	end

endmodule
